>>> hdl/pidl_pkg.sv
// Shared constants, codes and types of the positional insert/delete list.
`default_nettype none

package pidl_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_MID   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_MID   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_PREV,
      CELL_NEXT,
      CELL_HEAD
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> hdl/positional_insert_delete_list.sv
// Top level of the positional insert/delete list: controller, cell chain and result register.
//
// Usage: each request beat on req_ carries a mode and a data word. Inserts
// (front, back, middle) and deletes (front, back, middle) update the list
// at once, since the cells from the position onward shift together, and
// produce one response beat. A dump produces one response beat per held entry,
// in list order, with rsp_last on the final one; an empty dump, a refused
// insert or a refused delete gives one beat with an error status.
// Latency: a response beat appears in the cycle after its request is taken.
// Throughput: one request per cycle for inserts and deletes while the
// response register is free; a dump gives one beat per held entry, with
// the chain rotating one place per beat so that the head cell always holds
// the next entry, and req_stall is high until its last beat is loaded.
// A response that waits under rsp_stall holds its beat; the block keeps
// taking requests only as fast as the response register frees up.
// The capacity register is written through csr_, which is always ready and
// must only be written while the block is idle.
// Reset (synchronous, active high) empties the list, sets the capacity to
// ten and drops rsp_valid. Stored words need no clearing.
`default_nettype none

module positional_insert_delete_list (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [pidl_pkg::MODE_W-1:0]     req_mode,
   input  wire  [pidl_pkg::DATA_WIDTH-1:0] req_value,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [pidl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pidl_pkg::DATA_WIDTH-1:0] rsp_data_out,
   output logic                            rsp_last,
   output logic [pidl_pkg::CNT_W-1:0]      rsp_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [pidl_pkg::CAP_W-1:0]      csr_capacity
);
   import pidl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_DELETE,
      CHAIN_ROTATE
   } chain_op_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CAP_W-1:0]      capacity_ff, capacity_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic [DATA_WIDTH-1:0] word [DEPTH];
   cell_cmd_type          cmd [DEPTH];

   chain_op_type          chain_op;
   logic [CNT_W-1:0]      pos;
   logic [CNT_W-1:0]      mid;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      eff_cap;
   logic                  can_insert;
   logic                  out_free;
   logic                  req_accept;
   logic                  load;
   logic [STATUS_W-1:0]   load_status;
   logic [DATA_WIDTH-1:0] load_data;
   logic                  load_last;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign cap_ext    = CMP_W'(capacity_ff);
   assign eff_cap    = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign can_insert = CMP_W'(count_ff) < eff_cap;
   assign mid        = (count_ff == '0) ? '0 : ((count_ff - CNT_W'(1)) >> 1);

   always_comb begin
      capacity_in = (csr_valid && csr_ready) ? csr_capacity : capacity_ff;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      chain_op    = CHAIN_HOLD;
      pos         = '0;
      load        = 1'b0;
      load_status = STATUS_OK;
      load_data   = '0;
      load_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               load = 1'b1;
               unique case (req_mode)
                  MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_MID: begin
                     if (!can_insert) begin
                        load_status = STATUS_FULL;
                     end else begin
                        chain_op = CHAIN_INSERT;
                        count_in = count_ff + CNT_W'(1);
                        priority if (req_mode == MODE_INS_FRONT) begin
                           pos = '0;
                        end else if (req_mode == MODE_INS_BACK) begin
                           pos = count_ff;
                        end else begin
                           pos = mid;
                        end
                     end
                  end
                  MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_MID: begin
                     if (count_ff == '0) begin
                        load_status = STATUS_EMPTY;
                     end else begin
                        chain_op = CHAIN_DELETE;
                        count_in = count_ff - CNT_W'(1);
                        priority if (req_mode == MODE_DEL_FRONT) begin
                           pos = '0;
                        end else if (req_mode == MODE_DEL_BACK) begin
                           pos = count_ff - CNT_W'(1);
                        end else begin
                           pos = mid;
                        end
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff == '0) begin
                        load_status = STATUS_EMPTY;
                     end else begin
                        chain_op  = CHAIN_ROTATE;
                        load_data = word[0];
                        load_last = (count_ff == CNT_W'(1));
                        rem_in    = count_ff - CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           state_in = S_DUMP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               load      = 1'b1;
               chain_op  = CHAIN_ROTATE;
               load_data = word[0];
               load_last = (rem_ff == CNT_W'(1));
               rem_in    = rem_ff - CNT_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cmd[i] = CELL_HOLD;
         unique case (chain_op)
            CHAIN_INSERT: begin
               if (CNT_W'(i) > pos) begin
                  cmd[i] = CELL_PREV;
               end else if (CNT_W'(i) == pos) begin
                  cmd[i] = CELL_LOAD;
               end
            end
            CHAIN_DELETE: begin
               if (CNT_W'(i) >= pos) begin
                  cmd[i] = CELL_NEXT;
               end
            end
            CHAIN_ROTATE: begin
               if (CNT_W'(i) == count_ff - CNT_W'(1)) begin
                  cmd[i] = CELL_HEAD;
               end else begin
                  cmd[i] = CELL_NEXT;
               end
            end
            default: begin
               cmd[i] = CELL_HOLD;
            end
         endcase
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_word;
      logic [DATA_WIDTH-1:0] next_word;

      if (g == 0) begin : g_first
         assign prev_word = req_value;
      end else begin : g_inner_prev
         assign prev_word = word[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign next_word = word[g];
      end else begin : g_inner_next
         assign next_word = word[g+1];
      end

      pidl_cell u_cell (
         .clock     (clock),
         .cmd       (cmd[g]),
         .new_word  (req_value),
         .prev_word (prev_word),
         .next_word (next_word),
         .head_word (word[0]),
         .word      (word[g])
      );
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = load_status;
         rsp_data_in   = load_data;
         rsp_last_in   = load_last;
         rsp_count_in  = count_in;
         rsp_empty_in  = (count_in == '0);
         rsp_full_in   = CMP_W'(count_in) >= eff_cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_is_full  = rsp_full_ff;

   // The list never holds more words than there are cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the number of cells");

   // During a dump the remaining beat count stays within the held entries.
   a_dump_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (rem_ff != '0 && rem_ff < count_ff))
      else $error("dump beat counter out of range");

   // The entry count only moves when a request beat is taken.
   a_count_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(count_ff))
      else $error("entry count changed without a request");

   // Refused operations always answer with a single final beat.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_last_ff && rsp_data_ff == '0))
      else $error("error response is not a single final beat");

   // A dump in progress keeps the request side stalled.
   a_dump_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !req_accept)
      else $error("request taken while a dump is running");

endmodule

`default_nettype wire

>>> hdl/pidl_cell.sv
// One storage cell of the list chain, holding a single data word.
`default_nettype none

module pidl_cell (
   input  wire                              clock,
   input  pidl_pkg::cell_cmd_type           cmd,
   input  wire  [pidl_pkg::DATA_WIDTH-1:0]  new_word,
   input  wire  [pidl_pkg::DATA_WIDTH-1:0]  prev_word,
   input  wire  [pidl_pkg::DATA_WIDTH-1:0]  next_word,
   input  wire  [pidl_pkg::DATA_WIDTH-1:0]  head_word,
   output logic [pidl_pkg::DATA_WIDTH-1:0]  word
);
   import pidl_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      unique case (cmd)
         CELL_HOLD: word_in = word_ff;
         CELL_LOAD: word_in = new_word;
         CELL_PREV: word_in = prev_word;
         CELL_NEXT: word_in = next_word;
         CELL_HEAD: word_in = head_word;
         default:   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

>>> verif/positional_insert_delete_list_tb.sv
// Self-checking testbench of the positional insert/delete list with a list predictor.
`default_nettype none

module positional_insert_delete_list_tb;
   import pidl_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam int QUIET_LIMIT = 3000;
   localparam int NUM_DIRECTED = 24;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 46;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [DATA_WIDTH-1:0] data_out;
      logic                  last;
      logic [CNT_W-1:0]      count;
      logic                  is_empty;
      logic                  is_full;
   } list_beat_type;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [DATA_WIDTH-1:0] value;
      logic                  typed;
      logic [STATUS_W-1:0]   status;
      logic [CNT_W-1:0]      count;
   } list_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [DATA_WIDTH-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [DATA_WIDTH-1:0] rsp_data_out;
   logic                  rsp_last;
   logic [CNT_W-1:0]      rsp_count;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_capacity = '0;

   logic [DATA_WIDTH-1:0] list_words [DEPTH];
   int                    words_held = 0;
   int                    capacity_setting = int'(CAP_RESET);
   list_beat_type         pending_beats [$];
   int                    mismatches = 0;
   int                    quiet_cycles = 0;
   bit                    calm = 1'b0;

   list_step_type directed_steps [NUM_DIRECTED] = '{
      '{MODE_DUMP,      32'h0000_0000, 1'b1, STATUS_EMPTY, 5'd0},
      '{MODE_DEL_FRONT, 32'h0000_0000, 1'b1, STATUS_EMPTY, 5'd0},
      '{MODE_DEL_BACK,  32'hffff_ffff, 1'b1, STATUS_EMPTY, 5'd0},
      '{MODE_DEL_MID,   32'h0000_0000, 1'b1, STATUS_EMPTY, 5'd0},
      '{MODE_UNUSED,    32'hffff_ffff, 1'b1, STATUS_OK,    5'd0},
      '{MODE_INS_BACK,  32'hffff_ffff, 1'b1, STATUS_OK,    5'd1},
      '{MODE_INS_FRONT, 32'h0000_0000, 1'b1, STATUS_OK,    5'd2},
      '{MODE_INS_MID,   32'ha5a5_a5a5, 1'b1, STATUS_OK,    5'd3},
      '{MODE_DUMP,      32'h0000_0000, 1'b0, STATUS_OK,    5'd0},
      '{MODE_INS_MID,   32'h5a5a_5a5a, 1'b1, STATUS_OK,    5'd4},
      '{MODE_INS_BACK,  32'h8000_0000, 1'b1, STATUS_OK,    5'd5},
      '{MODE_INS_FRONT, 32'h0000_0001, 1'b1, STATUS_OK,    5'd6},
      '{MODE_INS_MID,   32'h7fff_ffff, 1'b1, STATUS_OK,    5'd7},
      '{MODE_INS_BACK,  32'h1234_5678, 1'b1, STATUS_OK,    5'd8},
      '{MODE_INS_MID,   32'hfedc_ba98, 1'b1, STATUS_OK,    5'd9},
      '{MODE_INS_FRONT, 32'h0f0f_0f0f, 1'b1, STATUS_OK,    5'd10},
      '{MODE_INS_BACK,  32'hdead_beef, 1'b1, STATUS_FULL,  5'd10},
      '{MODE_INS_MID,   32'hffff_ffff, 1'b1, STATUS_FULL,  5'd10},
      '{MODE_DUMP,      32'h0000_0000, 1'b0, STATUS_OK,    5'd0},
      '{MODE_DEL_MID,   32'h0000_0000, 1'b1, STATUS_OK,    5'd9},
      '{MODE_DEL_FRONT, 32'h0000_0000, 1'b1, STATUS_OK,    5'd8},
      '{MODE_DEL_BACK,  32'h0000_0000, 1'b1, STATUS_OK,    5'd7},
      '{MODE_UNUSED,    32'h0000_0000, 1'b1, STATUS_OK,    5'd7},
      '{MODE_DUMP,      32'h0000_0000, 1'b0, STATUS_OK,    5'd0}
   };

   int phase_capacity [NUM_PHASES] = '{16, 3, 0, 1, 31, 17, 7, 16};

   positional_insert_delete_list i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_last     (rsp_last),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_capacity (csr_capacity)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   function automatic int usable_capacity();
      return (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
   endfunction

   function automatic void push_beat(logic [STATUS_W-1:0] status,
                                     logic [DATA_WIDTH-1:0] data, logic last);
      list_beat_type beat;
      beat.status   = status;
      beat.data_out = data;
      beat.last     = last;
      beat.count    = CNT_W'(words_held);
      beat.is_empty = (words_held == 0);
      beat.is_full  = (words_held >= usable_capacity());
      pending_beats.push_back(beat);
   endfunction

   function automatic void predict_list_op(logic [MODE_W-1:0] mode,
                                           logic [DATA_WIDTH-1:0] value);
      int pos;
      int i;
      pos = (words_held == 0) ? 0 : (words_held - 1) / 2;
      case (mode)
         MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_MID: begin
            if (words_held >= usable_capacity()) begin
               push_beat(STATUS_FULL, '0, 1'b1);
            end else begin
               if (mode == MODE_INS_FRONT) pos = 0;
               if (mode == MODE_INS_BACK) pos = words_held;
               for (i = words_held; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = value;
               words_held++;
               push_beat(STATUS_OK, '0, 1'b1);
            end
         end
         MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_MID: begin
            if (words_held == 0) begin
               push_beat(STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (mode == MODE_DEL_FRONT) pos = 0;
               if (mode == MODE_DEL_BACK) pos = words_held - 1;
               for (i = pos; i + 1 < words_held; i++) list_words[i] = list_words[i+1];
               words_held--;
               push_beat(STATUS_OK, '0, 1'b1);
            end
         end
         MODE_DUMP: begin
            if (words_held == 0) begin
               push_beat(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < words_held; i++) begin
                  push_beat(STATUS_OK, list_words[i], i + 1 == words_held);
               end
            end
         end
         default: begin
            push_beat(STATUS_OK, '0, 1'b1);
         end
      endcase
   endfunction

   task automatic issue_request(logic [MODE_W-1:0] mode, logic [DATA_WIDTH-1:0] value,
                                logic typed, logic [STATUS_W-1:0] status,
                                logic [CNT_W-1:0] count);
      int last_idx;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predict_list_op(mode, value);
      if (typed) begin
         last_idx = pending_beats.size() - 1;
         pending_beats[last_idx].status = status;
         pending_beats[last_idx].count  = count;
      end
   endtask

   task automatic write_capacity(int cap);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= CAP_W'(cap);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity_setting = cap;
   endtask

   function automatic logic [DATA_WIDTH-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      list_beat_type seen;
      seen = '{rsp_status, rsp_data_out, rsp_last, rsp_count, rsp_is_empty, rsp_is_full};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            mismatches++;
            $display("%0t: beat with none expected: status %0d data %h last %0d count %0d",
                     $time, seen.status, seen.data_out, seen.last, seen.count);
         end else begin
            if (seen !== pending_beats[0]) begin
               mismatches++;
               $display("%0t: expected status %0d data %h last %0d count %0d empty %0d full %0d",
                        $time, pending_beats[0].status, pending_beats[0].data_out,
                        pending_beats[0].last, pending_beats[0].count,
                        pending_beats[0].is_empty, pending_beats[0].is_full);
               $display("%0t: actual   status %0d data %h last %0d count %0d empty %0d full %0d",
                        $time, seen.status, seen.data_out, seen.last, seen.count,
                        seen.is_empty, seen.is_full);
            end
            void'(pending_beats.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("positional_insert_delete_list: mismatch");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int phase;
      int n;
      int run_left;
      int fill_pct;
      int pick;
      logic [MODE_W-1:0] mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         issue_request(directed_steps[k].mode, directed_steps[k].value,
                       directed_steps[k].typed, directed_steps[k].status,
                       directed_steps[k].count);
      end
      req_valid <= 1'b0;

      run_left = 0;
      fill_pct = 80;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_capacity(phase_capacity[phase]);
         if (phase == NUM_PHASES - 1) calm = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(8, 30);
               fill_pct = (fill_pct > 50) ? 25 : 80;
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               mode = MODE_UNUSED;
            end else if (pick < 13) begin
               mode = MODE_DUMP;
            end else if ($urandom_range(0, 99) < fill_pct) begin
               mode = MODE_W'($urandom_range(int'(MODE_INS_FRONT), int'(MODE_INS_MID)));
            end else begin
               mode = MODE_W'($urandom_range(int'(MODE_DEL_FRONT), int'(MODE_DEL_MID)));
            end
            issue_request(mode, random_word(), 1'b0, STATUS_OK, '0);
         end
         req_valid <= 1'b0;
      end

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_beats.size() == 0) begin
         $display("positional_insert_delete_list: match");
      end else begin
         $display("positional_insert_delete_list: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
hdl/pidl_pkg.sv
hdl/pidl_cell.sv
hdl/positional_insert_delete_list.sv
verif/positional_insert_delete_list_tb.sv
